// ----- design/rs_pkg.sv -----
// Shared types and constants for the row sorter.
package rs_pkg;

   // Depth of the word queue between the sorting front end and the output stage.
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      ST_LOAD  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

endpackage

// ----- design/rs_front.sv -----
// Front end: compare-insert cell chain that loads a row, then shifts it out in order.
module rs_front #(
   parameter int ROW_LEN     = 16,
   parameter int VALUE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                          push,
   output logic signed [VALUE_WIDTH-1:0] push_value,
   output logic                          push_row_end,
   input  logic                          full
);

   localparam int CW = $clog2(ROW_LEN + 1);

   rs_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic signed [VALUE_WIDTH-1:0] cell_ff [ROW_LEN];
   logic signed [VALUE_WIDTH-1:0] cell_in [ROW_LEN];
   logic [ROW_LEN-1:0] lt;
   logic accept;
   logic shift;

   assign req_stall    = (state_ff != rs_pkg::ST_LOAD);
   assign accept       = req_valid && !req_stall;
   assign shift        = (state_ff == rs_pkg::ST_DRAIN) && !full;
   assign push         = shift;
   assign push_value   = cell_ff[0];
   assign push_row_end = (count_ff == CW'(1));

   // Cells hold the loaded words in ascending order; empty cells sit at the top end.
   always_comb begin
      for (int i = 0; i < ROW_LEN; i++) begin
         lt[i] = (CW'(i) >= count_ff) || (req_value < cell_ff[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < ROW_LEN; i++) begin
         cell_in[i] = cell_ff[i];
         if (accept) begin
            if (lt[i]) begin
               if (i == 0) begin
                  cell_in[i] = req_value;
               end else if (!lt[i-1]) begin
                  cell_in[i] = req_value;
               end else begin
                  cell_in[i] = cell_ff[i-1];
               end
            end
         end else if (shift) begin
            if (i < ROW_LEN - 1) begin
               cell_in[i] = cell_ff[i+1];
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      unique case (state_ff)
         rs_pkg::ST_LOAD: begin
            if (accept) begin
               count_in = count_ff + CW'(1);
               if (count_ff == CW'(ROW_LEN - 1)) begin
                  state_in = rs_pkg::ST_DRAIN;
               end
            end
         end
         rs_pkg::ST_DRAIN: begin
            if (shift) begin
               count_in = count_ff - CW'(1);
               if (count_ff == CW'(1)) begin
                  state_in = rs_pkg::ST_LOAD;
               end
            end
         end
         default: begin
            state_in = rs_pkg::ST_LOAD;
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rs_pkg::ST_LOAD;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ROW_LEN; i++) begin
         cell_ff[i] <= cell_in[i];
      end
   end

endmodule

// ----- design/rs_queue.sv -----
// Short word queue between the front end and the output stage.
module rs_queue #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic signed [VALUE_WIDTH-1:0] push_value,
   input  logic                          push_row_end,
   output logic                          full,
   input  logic                          pop,
   output logic signed [VALUE_WIDTH-1:0] pop_value,
   output logic                          pop_row_end,
   output logic                          empty
);

   localparam int PW = $clog2(rs_pkg::QUEUE_DEPTH);

   logic [VALUE_WIDTH:0] entry_ff [rs_pkg::QUEUE_DEPTH];
   logic [PW:0] wr_ptr_ff, wr_ptr_in;
   logic [PW:0] rd_ptr_ff, rd_ptr_in;

   assign empty = (wr_ptr_ff == rd_ptr_ff);
   assign full  = (wr_ptr_ff[PW] != rd_ptr_ff[PW]) &&
                  (wr_ptr_ff[PW-1:0] == rd_ptr_ff[PW-1:0]);

   assign pop_value   = entry_ff[rd_ptr_ff[PW-1:0]][VALUE_WIDTH-1:0];
   assign pop_row_end = entry_ff[rd_ptr_ff[PW-1:0]][VALUE_WIDTH];

   assign wr_ptr_in = wr_ptr_ff + (PW+1)'(push && !full);
   assign rd_ptr_in = rd_ptr_ff + (PW+1)'(pop && !empty);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         entry_ff[wr_ptr_ff[PW-1:0]] <= {push_row_end, push_value};
      end
   end

endmodule

// ----- design/rs_back.sv -----
// Output stage: registered result word fed from the queue.
module rs_back #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          empty,
   input  logic signed [VALUE_WIDTH-1:0] pop_value,
   input  logic                          pop_row_end,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [VALUE_WIDTH-1:0] rsp_sorted_value,
   output logic                          rsp_row_end
);

   logic valid_ff, valid_in;
   logic signed [VALUE_WIDTH-1:0] value_ff;
   logic row_end_ff;
   logic load;

   // Refill whenever the held word leaves or the register is empty.
   assign load     = !valid_ff || !rsp_stall;
   assign pop      = load && !empty;
   assign valid_in = load ? !empty : valid_ff;

   assign rsp_valid        = valid_ff;
   assign rsp_sorted_value = value_ff;
   assign rsp_row_end      = row_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         value_ff   <= pop_value;
         row_end_ff <= pop_row_end;
      end
   end

endmodule

// ----- design/row_sorter.sv -----
// Row sorter top level: sorts fixed-length rows of signed words into ascending order.
// A row of ROW_LEN words is taken one word per cycle into a chain of compare-insert
// cells, which keeps the row in order as it loads. Once the last word of the row is in,
// the input stalls while the chain shifts the sorted row out, one word per cycle while the
// queue has room, into a four-word queue ahead of the output register; rsp_row_end marks
// the largest word. The chain has a single shift-out port, so it takes no new row until
// the last row has been shifted out. Equal words come out adjacent in any order. No
// clearing is needed after reset.
module row_sorter #(
   parameter int ROW_LEN     = 16,
   parameter int VALUE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [VALUE_WIDTH-1:0] rsp_sorted_value,
   output logic                          rsp_row_end
);

   logic                          push;
   logic signed [VALUE_WIDTH-1:0] push_value;
   logic                          push_row_end;
   logic                          full;
   logic                          pop;
   logic signed [VALUE_WIDTH-1:0] pop_value;
   logic                          pop_row_end;
   logic                          empty;

   rs_front #(
      .ROW_LEN     (ROW_LEN),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value    (req_value),
      .push         (push),
      .push_value   (push_value),
      .push_row_end (push_row_end),
      .full         (full)
   );

   rs_queue #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_value   (push_value),
      .push_row_end (push_row_end),
      .full         (full),
      .pop          (pop),
      .pop_value    (pop_value),
      .pop_row_end  (pop_row_end),
      .empty        (empty)
   );

   rs_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .empty            (empty),
      .pop_value        (pop_value),
      .pop_row_end      (pop_row_end),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_row_end      (rsp_row_end)
   );

endmodule

// ----- verif/row_sorter_test.sv -----
// Self-checking testbench for row_sorter: random and directed rows against a sorting predictor.
module row_sorter_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROW_LEN      = 16;
   localparam int VALUE_WIDTH  = 16;
   localparam int DIRECTED_LEN = 24;
   localparam int ITEM_TOTAL   = 432;   // whole rows only, so every word loaded comes back
   localparam int CALM_FROM    = 380;
   localparam int HOLD_AT      = 120;
   localparam int PAUSE_AT     = 256;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 2 * ROW_LEN + 16;
   localparam int CYCLE_LIMIT  = 200000;

   typedef logic signed [VALUE_WIDTH-1:0] word_t;

   typedef struct {
      word_t value;
      logic  row_end;
   } sorted_word_t;

   typedef enum int {
      PAT_RANDOM,
      PAT_NARROW,
      PAT_RISING,
      PAT_FALLING,
      PAT_EDGES
   } row_pattern_t;

   class sorted_row_board;
      word_t        row_buf[ROW_LEN];
      int           fill_count;
      sorted_word_t expected_q[$];
      int           mismatches;

      function new();
         fill_count = 0;
         mismatches = 0;
      endfunction

      // Load one word; on the last word of a row queue the row in ascending order.
      function void note_word(word_t v);
         word_t        key;
         sorted_word_t e;
         int           i;
         int           j;
         row_buf[fill_count] = v;
         fill_count++;
         if (fill_count < ROW_LEN) return;
         fill_count = 0;
         for (i = 1; i < ROW_LEN; i++) begin
            key = row_buf[i];
            j = i - 1;
            while (j >= 0 && row_buf[j] > key) begin
               row_buf[j + 1] = row_buf[j];
               j--;
            end
            row_buf[j + 1] = key;
         end
         for (i = 0; i < ROW_LEN; i++) begin
            e.value   = row_buf[i];
            e.row_end = (i == ROW_LEN - 1);
            expected_q.push_back(e);
         end
      endfunction

      function void check_word(word_t v, logic last);
         sorted_word_t e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected word: sorted_value %0d row_end %0b", $time, v, last);
            mismatches++;
            return;
         end
         e = expected_q.pop_front();
         if (v !== e.value) begin
            $display("%0t: sorted_value expected %0d actual %0d", $time, e.value, v);
            mismatches++;
         end
         if (last !== e.row_end) begin
            $display("%0t: row_end expected %0b actual %0b", $time, e.row_end, last);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic  clock     = 1'b0;
   logic  reset     = 1'b1;
   logic  req_valid = 1'b0;
   word_t req_value = '0;
   logic  rsp_stall = 1'b0;
   logic  req_stall;
   logic  rsp_valid;
   word_t rsp_sorted_value;
   logic  rsp_row_end;

   bit    calm       = 1'b0;
   bit    hold_asked = 1'b0;
   int    cycle_count = 0;

   sorted_row_board board = new();

   row_sorter #(
      .ROW_LEN    (ROW_LEN),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sorted_value(rsp_sorted_value),
      .rsp_row_end     (rsp_row_end)
   );

   always #4 clock = ~clock;

   // Sample both handshakes with the values that held up to the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_word(req_value);
         if (rsp_valid && !rsp_stall) board.check_word(rsp_sorted_value, rsp_row_end);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic word_t row_word(row_pattern_t pattern, int pos, word_t base);
      case (pattern)
         PAT_NARROW:  return word_t'(int'($urandom_range(0, 6)) - 3);
         PAT_RISING:  return base + word_t'(pos * 37);
         PAT_FALLING: return base - word_t'(pos * 37);
         PAT_EDGES: begin
            case ($urandom_range(0, 3))
               0:       return word_t'(-32768);
               1:       return word_t'(32767);
               2:       return word_t'(0);
               default: return word_t'(-1);
            endcase
         end
         default:     return word_t'($urandom);
      endcase
   endfunction

   // Valid stays up until the word is taken; the caller decides whether it drops.
   task automatic offer_word(word_t v);
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (req_stall);
   endtask

   initial begin
      forever begin
         if (hold_asked) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_asked = 1'b0;
         end else if (calm) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   initial begin
      // First row: extremes, alternating bit patterns and duplicates, largest first.
      // Then a run of equal words that random words complete.
      word_t directed_words[DIRECTED_LEN] = '{
         32767, 16384, 255, 1, 0, 0, -1, -2,
         -256, -16385, -32767, -32768, 32767, -32768, 21845, -21846,
         7, 7, 7, 7, 7, 7, 7, 7
      };
      row_pattern_t pattern;
      word_t        base;
      word_t        v;
      int           n;

      pattern = PAT_RANDOM;
      base    = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (n = 0; n < ITEM_TOTAL; n++) begin
         calm = (n >= CALM_FROM);
         if (n == HOLD_AT) hold_asked = 1'b1;
         if (n == PAUSE_AT) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (board.pending() != 0);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         if (n >= DIRECTED_LEN && n % ROW_LEN == 0) begin
            pattern = ($urandom_range(0, 7) >= 4) ? PAT_RANDOM
                                                  : row_pattern_t'($urandom_range(1, 4));
            base    = word_t'($urandom);
         end
         v = (n < DIRECTED_LEN) ? directed_words[n] : row_word(pattern, n % ROW_LEN, base);
         offer_word(v);
      end
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- row_sorter.f -----
design/rs_pkg.sv
design/rs_front.sv
design/rs_queue.sv
design/rs_back.sv
design/row_sorter.sv
verif/row_sorter_test.sv
